// ===== design/nidm_pkg.sv =====
// Shared types and constants for the nearest idle driver matcher.
// Used by nearest_idle_driver_matcher_unit; no dependencies.
`default_nettype none

package nidm_pkg;

  localparam int MAX_DRIVERS_DEF = 64;
  localparam int COORD_BITS_DEF  = 16;

  // Field widths of the stream items
  localparam int SLOT_W     = 6;
  localparam int POS_W      = 16;
  localparam int ID_W       = 16;
  localparam int TICK_W     = 32;
  localparam int COUNT_W    = 7;
  localparam int BUSY_W     = 16;
  localparam int IN_DATA_W  = 120;
  localparam int OUT_DATA_W = 120;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 1;

  // Item kinds on the input tuser
  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_MATCH = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DRIVER_COUNT  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_BUSY_DURATION = 1'b1;

  localparam logic [BUSY_W-1:0] BUSY_RESET = 16'd5;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOAD_RD,
    ST_LOAD_WR,
    ST_SCAN,
    ST_DRAIN,
    ST_COMMIT,
    ST_RESULT
  } state_t;

endpackage

`default_nettype wire

// ===== design/nearest_idle_driver_matcher_unit.sv =====
// Nearest idle driver matcher: driver table in one memory and a pipelined distance unit.
// Depends on nidm_pkg.
`default_nettype none

// After reset the block clears the driver table, one slot a cycle, and takes no item
// meanwhile. A load item is a read-modify-write of one slot so the busy-until tick survives.
// A rider item with n = min(slot count, MAX_DRIVERS) goes through these steps in order:
// accept, issue the table reads one slot per cycle, drain the distance unit (read, abs
// difference, square, add and compare), write the busy mark of the winner (skipped when no
// driver is idle) and hand the result to the output register, which waits on a full output
// register. With n = 0 no table read is issued. One item is in work at a time; a finished
// result may wait on m_tready while the next item is accepted.
module nearest_idle_driver_matcher_unit #(
  parameter int MAX_DRIVERS = nidm_pkg::MAX_DRIVERS_DEF,
  parameter int COORD_BITS  = nidm_pkg::COORD_BITS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  // slave side
  input  wire logic                             s_tvalid,
  output logic                                  s_tready,
  // slot, pos_x, pos_y, driver id, idle mark, rider tick, now_tick, zero pad
  input  wire logic [nidm_pkg::IN_DATA_W-1:0]   s_tdata,
  // req_type
  input  wire logic                             s_tuser,
  // last_rider
  input  wire logic                             s_tlast,
  // master side
  output logic                                  m_tvalid,
  input  wire logic                             m_tready,
  // driver id, matched_slot, match tick, wait, match_total, zero pad
  output logic [nidm_pkg::OUT_DATA_W-1:0]       m_tdata,
  // matched
  output logic                                  m_tuser,
  // configuration writes
  input  wire logic                             cfg_we,
  input  wire logic [nidm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [nidm_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int CB     = COORD_BITS;
  localparam int AW     = (MAX_DRIVERS > 1) ? $clog2(MAX_DRIVERS) : 1;
  localparam int CNT_W  = $clog2(MAX_DRIVERS + 1);
  localparam int DW     = 2 * CB + 1;
  localparam int TW     = nidm_pkg::TICK_W;
  localparam int IDW    = nidm_pkg::ID_W;
  localparam int SW     = nidm_pkg::SLOT_W;
  // table entry: x, y, id, busy-until, idle
  localparam int X_LO   = 0;
  localparam int Y_LO   = CB;
  localparam int ID_LO  = 2 * CB;
  localparam int BSY_LO = ID_LO + IDW;
  localparam int IDL_B  = BSY_LO + TW;
  localparam int EW     = IDL_B + 1;
  localparam int XW     = (CB > nidm_pkg::POS_W) ? CB : nidm_pkg::POS_W;
  localparam int AXW    = (AW > SW) ? AW : SW;

  // ---------------------------------------------------------------- input fields
  logic [SW-1:0]  in_slot;
  logic [AXW-1:0] in_slot_wide;
  logic [XW-1:0]  in_x_wide, in_y_wide;
  logic [CB-1:0]  in_x, in_y;
  logic [IDW-1:0] in_id;
  logic           in_idle;
  logic [TW-1:0]  in_req_tick, in_now_tick;
  logic           in_slot_ok;
  logic           accept;

  assign in_slot      = s_tdata[5:0];
  assign in_slot_wide = AXW'(in_slot);
  assign in_x_wide    = XW'(s_tdata[21:6]);
  assign in_y_wide    = XW'(s_tdata[37:22]);
  assign in_x         = in_x_wide[CB-1:0];
  assign in_y         = in_y_wide[CB-1:0];
  assign in_id        = s_tdata[53:38];
  assign in_idle      = s_tdata[54];
  assign in_req_tick  = s_tdata[86:55];
  assign in_now_tick  = s_tdata[118:87];
  assign in_slot_ok   = (32'(in_slot) < MAX_DRIVERS);
  assign accept       = s_tvalid && s_tready;

  // ---------------------------------------------------------------- registers
  nidm_pkg::state_t state, state_next;

  logic [nidm_pkg::COUNT_W-1:0] slot_count;
  logic [nidm_pkg::BUSY_W-1:0]  busy_duration;
  logic [TW-1:0]                batch_matches;

  logic [AW-1:0]  clr_addr;
  logic [AW-1:0]  ld_addr;
  logic [CB-1:0]  pos_x, pos_y;
  logic [IDW-1:0] ld_id;
  logic           ld_idle;
  logic [TW-1:0]  req_tick, now_tick;
  logic           last;

  logic [CNT_W-1:0] issue_cnt;
  logic [CNT_W-1:0] scan_n;

  // driver table
  logic [EW-1:0]  mem [MAX_DRIVERS];
  logic [EW-1:0]  rd_data;
  logic           mem_we;
  logic [AW-1:0]  mem_waddr, mem_raddr;
  logic [EW-1:0]  mem_wdata;

  // distance pipeline
  logic           issue;
  logic           p0_v;
  logic [AW-1:0]  p0_slot;
  logic           p1_v;
  logic [AW-1:0]  p1_slot;
  logic [EW-1:0]  p1_entry;
  logic [CB-1:0]  p1_dx, p1_dy;
  logic           p2_v;
  logic [AW-1:0]  p2_slot;
  logic [EW-1:0]  p2_entry;
  logic [2*CB-1:0] p2_sqx, p2_sqy;

  logic           found;
  logic [AW-1:0]  best_slot;
  logic [EW-1:0]  best_entry;
  logic [DW-1:0]  best_dist;

  // output register
  logic           out_valid;
  logic           out_matched;
  logic [IDW-1:0] out_id;
  logic [SW-1:0]  out_slot;
  logic [TW-1:0]  out_tick, out_wait, out_total;
  logic           out_load;
  logic           out_free;

  assign out_free = !out_valid || m_tready;
  assign scan_n = (32'(slot_count) > MAX_DRIVERS) ? CNT_W'(MAX_DRIVERS)
                                                   : CNT_W'(slot_count);

  // ---------------------------------------------------------------- next state
  always_comb begin
    state_next = state;
    case (state)
      nidm_pkg::ST_CLEAR: begin
        if (clr_addr == AW'(MAX_DRIVERS - 1)) state_next = nidm_pkg::ST_IDLE;
      end
      nidm_pkg::ST_IDLE: begin
        if (accept) begin
          if (s_tuser == nidm_pkg::REQ_MATCH) state_next = nidm_pkg::ST_SCAN;
          else if (in_slot_ok)                state_next = nidm_pkg::ST_LOAD_RD;
        end
      end
      nidm_pkg::ST_LOAD_RD: state_next = nidm_pkg::ST_LOAD_WR;
      nidm_pkg::ST_LOAD_WR: state_next = nidm_pkg::ST_IDLE;
      nidm_pkg::ST_SCAN: begin
        if (issue_cnt == scan_n) state_next = nidm_pkg::ST_DRAIN;
      end
      nidm_pkg::ST_DRAIN: begin
        if (!p0_v && !p1_v && !p2_v)
          state_next = found ? nidm_pkg::ST_COMMIT : nidm_pkg::ST_RESULT;
      end
      nidm_pkg::ST_COMMIT: state_next = nidm_pkg::ST_RESULT;
      nidm_pkg::ST_RESULT: begin
        if (out_free) state_next = nidm_pkg::ST_IDLE;
      end
      default: state_next = nidm_pkg::ST_CLEAR;
    endcase
  end

  // ---------------------------------------------------------------- outputs of the sequencer
  always_comb begin
    s_tready  = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = ld_addr;
    mem_wdata = '0;
    mem_raddr = ld_addr;
    issue     = 1'b0;
    out_load  = 1'b0;
    case (state)
      nidm_pkg::ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr;
      end
      nidm_pkg::ST_IDLE: s_tready = 1'b1;
      nidm_pkg::ST_LOAD_RD: mem_raddr = ld_addr;
      nidm_pkg::ST_LOAD_WR: begin
        // keep the stored busy-until tick
        mem_we    = 1'b1;
        mem_waddr = ld_addr;
        mem_wdata = {ld_idle, rd_data[BSY_LO +: TW], ld_id, pos_y, pos_x};
      end
      nidm_pkg::ST_SCAN: begin
        issue     = (issue_cnt != scan_n);
        mem_raddr = issue_cnt[AW-1:0];
      end
      nidm_pkg::ST_DRAIN: ;
      nidm_pkg::ST_COMMIT: begin
        mem_we    = 1'b1;
        mem_waddr = best_slot;
        mem_wdata = {1'b0, now_tick + TW'(busy_duration), best_entry[ID_LO +: IDW],
                     best_entry[Y_LO +: CB], best_entry[X_LO +: CB]};
      end
      nidm_pkg::ST_RESULT: out_load = out_free;
      default: ;
    endcase
  end

  // ---------------------------------------------------------------- memory
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rd_data <= mem[mem_raddr];
  end

  // ---------------------------------------------------------------- control and config
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= nidm_pkg::ST_CLEAR;
      clr_addr      <= '0;
      slot_count    <= '0;
      busy_duration <= nidm_pkg::BUSY_RESET;
      batch_matches <= '0;
      issue_cnt     <= '0;
      p0_v          <= 1'b0;
      p1_v          <= 1'b0;
      p2_v          <= 1'b0;
      found         <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      state <= state_next;
      if (state == nidm_pkg::ST_CLEAR) clr_addr <= clr_addr + AW'(1);

      if (cfg_we) begin
        case (cfg_index)
          nidm_pkg::CFG_DRIVER_COUNT:  slot_count    <= cfg_data[nidm_pkg::COUNT_W-1:0];
          nidm_pkg::CFG_BUSY_DURATION: busy_duration <= cfg_data;
          default: ;
        endcase
      end

      if (accept) issue_cnt <= '0;
      else if (issue) issue_cnt <= issue_cnt + CNT_W'(1);

      p0_v <= issue;
      p1_v <= p0_v && rd_data[IDL_B];
      p2_v <= p1_v;

      if (accept) found <= 1'b0;
      else if (p2_v && (!found || (({1'b0, p2_sqx} + {1'b0, p2_sqy}) < best_dist)))
        found <= 1'b1;

      if (out_load) begin
        out_valid     <= 1'b1;
        batch_matches <= last ? '0 : batch_matches + TW'(found);
      end else if (m_tvalid && m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------- payload
  logic [DW-1:0]  cand_dist;
  logic [CB:0]    diff_x, diff_y;
  logic [CB:0]    adx, ady;
  logic [AXW-1:0] best_slot_wide;

  assign cand_dist = {1'b0, p2_sqx} + {1'b0, p2_sqy};
  assign diff_x = $signed({rd_data[X_LO + CB - 1], rd_data[X_LO +: CB]})
                - $signed({pos_x[CB-1], pos_x});
  assign diff_y = $signed({rd_data[Y_LO + CB - 1], rd_data[Y_LO +: CB]})
                - $signed({pos_y[CB-1], pos_y});
  assign adx    = diff_x[CB] ? (~diff_x + (CB+1)'(1)) : diff_x;
  assign ady    = diff_y[CB] ? (~diff_y + (CB+1)'(1)) : diff_y;
  assign best_slot_wide = AXW'(best_slot);

  always_ff @(posedge clk) begin
    if (accept) begin
      ld_addr  <= in_slot_wide[AW-1:0] & AW'({AW{in_slot_ok}});
      pos_x    <= in_x;
      pos_y    <= in_y;
      ld_id    <= in_id;
      ld_idle  <= in_idle;
      req_tick <= in_req_tick;
      now_tick <= in_now_tick;
      last     <= s_tlast;
    end

    p0_slot  <= issue_cnt[AW-1:0];
    p1_slot  <= p0_slot;
    p1_entry <= rd_data;
    p1_dx    <= adx[CB-1:0];
    p1_dy    <= ady[CB-1:0];
    p2_slot  <= p1_slot;
    p2_entry <= p1_entry;
    p2_sqx   <= p1_dx * p1_dx;
    p2_sqy   <= p1_dy * p1_dy;

    // strictly smaller wins, so the lower slot keeps a tie
    if (p2_v && (!found || cand_dist < best_dist)) begin
      best_slot  <= p2_slot;
      best_entry <= p2_entry;
      best_dist  <= cand_dist;
    end

    if (out_load) begin
      out_matched <= found;
      out_id      <= found ? best_entry[ID_LO +: IDW] : '0;
      out_slot    <= found ? best_slot_wide[SW-1:0] : '0;
      out_tick    <= found ? now_tick : '0;
      out_wait    <= found ? (now_tick - req_tick) : '0;
      out_total   <= batch_matches + TW'(found);
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_matched;
  assign m_tdata  = {2'b00, out_total, out_wait, out_tick, out_slot, out_id};

  // ---------------------------------------------------------------- assertions
  a_no_accept_while_busy: assert property (@(posedge clk) disable iff (rst)
    (accept && s_tuser == nidm_pkg::REQ_MATCH) |=> !s_tready)
    else $error("rider accepted while a search is in work");

  a_idle_pipe_empty: assert property (@(posedge clk) disable iff (rst)
    (state == nidm_pkg::ST_IDLE) |-> (!p0_v && !p1_v && !p2_v))
    else $error("distance pipeline busy outside a search");

  a_commit_needs_winner: assert property (@(posedge clk) disable iff (rst)
    (state == nidm_pkg::ST_COMMIT) |-> found)
    else $error("busy mark written without a winner");

  a_winner_in_range: assert property (@(posedge clk) disable iff (rst)
    (out_load && found) |-> (CNT_W'(best_slot) < scan_n))
    else $error("winning slot beyond the searched range");

  a_no_write_in_scan: assert property (@(posedge clk) disable iff (rst)
    (state == nidm_pkg::ST_SCAN || state == nidm_pkg::ST_DRAIN) |-> !mem_we)
    else $error("table written during a search");

endmodule

`default_nettype wire
